// ===== src/greedy_square_mask_cover_assert.svh =====
// Assertion macros for the mask cover RTL.
`ifndef GREEDY_SQUARE_MASK_COVER_ASSERT_SVH
`define GREEDY_SQUARE_MASK_COVER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GSMC_ASSERT_IMP(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("gsmc assertion failed");

// Next-cycle implication, disabled while in reset.
`define GSMC_ASSERT_NXT(label, c, r, ante, cons) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("gsmc assertion failed");

`endif

// ===== src/gsmc_pkg.sv =====
`timescale 1ns / 1ps
package gsmc_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Register indexes on the configuration port
  localparam logic REG_WIDTH_IN_USE  = 1'b0;
  localparam logic REG_HEIGHT_IN_USE = 1'b1;

  localparam logic [8:0] CFG_RESET = 9'd256;

  // Command kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SQUARE = 1'b1;

  typedef struct packed {
    logic       found;
    logic [7:0] corner_x;
    logic [7:0] corner_y;
    logic [8:0] side;
  } result_t;

endpackage

// ===== src/gsmc_cfg.sv =====
`timescale 1ns / 1ps
module gsmc_cfg import gsmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  width_in_use,
  output logic [8:0]  height_in_use
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= CFG_RESET;
      height_in_use <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH_IN_USE:  width_in_use  <= pwdata[8:0];
        REG_HEIGHT_IN_USE: height_in_use <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH_IN_USE:  prdata = {23'd0, width_in_use};
      REG_HEIGHT_IN_USE: prdata = {23'd0, height_in_use};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/gsmc_mask_ram.sv =====
`timescale 1ns / 1ps
module gsmc_mask_ram #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic                     rdata_a,
  output logic                     rdata_b
);

  logic mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/gsmc_ctrl.sv =====
`timescale 1ns / 1ps
`include "greedy_square_mask_cover_assert.svh"
module gsmc_ctrl import gsmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    kind,
  input  logic [7:0]                              pixel_x,
  input  logic [7:0]                              pixel_y,
  input  logic                                    pixel_value,
  input  logic [8:0]                              width_in_use,
  input  logic [8:0]                              height_in_use,
  output logic                                    done,
  output result_t                                 res,
  output logic                                    mem_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_waddr,
  output logic                                    mem_wdata,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_raddr_a,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_raddr_b,
  input  logic                                    mem_rdata_a,
  input  logic                                    mem_rdata_b
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int VW    = ((XW > 9) ? XW : 9) + 1;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_GROW  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] init_cnt;
  logic [VW-1:0] cur_x, cur_y;
  logic [VW-1:0] pend_x, pend_y;
  logic          pend_v;
  logic [VW-1:0] grow, tap;
  logic          issued_all, gpend_v, gpend_last;
  logic [VW-1:0] cbx, cby;

  logic [VW-1:0] act_w, act_h, far_row, far_col;
  logic          accept, wr_item, pix_in, both_set;

  function automatic logic [AW-1:0] pix_addr(input logic [VW-1:0] x, input logic [VW-1:0] y);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  assign act_w = (VW'(width_in_use) < VW'(MAX_WIDTH)) ? VW'(width_in_use) : VW'(MAX_WIDTH);
  assign act_h = (VW'(height_in_use) < VW'(MAX_HEIGHT)) ? VW'(height_in_use)
                                                         : VW'(MAX_HEIGHT);
  assign far_row  = cur_y + grow + VW'(1);
  assign far_col  = cur_x + grow + VW'(1);
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign wr_item  = accept && (kind == KIND_WRITE);
  assign pix_in   = (VW'(pixel_x) < VW'(MAX_WIDTH)) && (VW'(pixel_y) < VW'(MAX_HEIGHT));
  assign both_set = mem_rdata_a && mem_rdata_b;

  // Read ports: scan probe on A, bottom row on A and right column on B while growing
  assign mem_raddr_a = (state == S_SCAN) ? pix_addr(cur_x, cur_y)
                                         : pix_addr(cur_x + tap, far_row);
  assign mem_raddr_b = pix_addr(far_col, cur_y + tap);

  always_comb begin
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
        mem_wdata = 1'b0;
      end
      S_IDLE: begin
        mem_we    = wr_item && pix_in;
        mem_waddr = pix_addr(VW'(pixel_x), VW'(pixel_y));
        mem_wdata = pixel_value;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = pix_addr(cur_x + cbx, cur_y + cby);
        mem_wdata = 1'b0;
      end
      default: begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_cnt   <= '0;
      cur_x      <= '0;
      cur_y      <= '0;
      pend_v     <= 1'b0;
      issued_all <= 1'b0;
      gpend_v    <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + AW'(1);
          if (init_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (wr_item) begin
            cur_x <= '0;
            cur_y <= '0;
          end else if (accept) begin
            pend_v <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pend_v && mem_rdata_a) begin
            // set pixel found: park the cursor on it and start growing
            cur_x      <= pend_x;
            cur_y      <= pend_y;
            grow       <= '0;
            tap        <= '0;
            issued_all <= 1'b0;
            gpend_v    <= 1'b0;
            pend_v     <= 1'b0;
            state      <= S_GROW;
          end else if (cur_x >= act_w) begin
            cur_y        <= '0;
            pend_v       <= 1'b0;
            res.found    <= 1'b0;
            res.corner_x <= '0;
            res.corner_y <= '0;
            res.side     <= '0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (cur_y >= act_h) begin
            cur_x  <= cur_x + VW'(1);
            cur_y  <= '0;
            pend_v <= 1'b0;
          end else begin
            pend_x <= cur_x;
            pend_y <= cur_y;
            pend_v <= 1'b1;
            cur_y  <= cur_y + VW'(1);
          end
        end
        S_GROW: begin
          if ((gpend_v && !both_set) ||
              (!gpend_v && !issued_all && tap == '0 &&
               (far_row >= act_h || far_col >= act_w))) begin
            cbx     <= '0;
            cby     <= '0;
            gpend_v <= 1'b0;
            state   <= S_CLEAR;
          end else if (gpend_v && gpend_last) begin
            grow       <= grow + VW'(1);
            tap        <= '0;
            issued_all <= 1'b0;
            gpend_v    <= 1'b0;
          end else if (!issued_all) begin
            if (tap == '0 && (far_row >= act_h || far_col >= act_w)) begin
              cbx     <= '0;
              cby     <= '0;
              gpend_v <= 1'b0;
              state   <= S_CLEAR;
            end else begin
              gpend_v    <= 1'b1;
              gpend_last <= (tap == grow + VW'(1));
              issued_all <= (tap == grow + VW'(1));
              tap        <= tap + VW'(1);
            end
          end else begin
            gpend_v <= 1'b0;
          end
        end
        S_CLEAR: begin
          if (cby == grow) begin
            cby <= '0;
            cbx <= cbx + VW'(1);
          end else begin
            cby <= cby + VW'(1);
          end
          if (cbx == grow && cby == grow) begin
            res.found    <= 1'b1;
            res.corner_x <= cur_x[7:0];
            res.corner_y <= cur_y[7:0];
            res.side     <= 9'(grow + VW'(1));
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GSMC_ASSERT_IMP(a_done_after_work, clk, rst, done, $past(state) != S_IDLE)
  `GSMC_ASSERT_IMP(a_miss_zero, clk, rst, done && !res.found,
                   res.side == 9'd0 && res.corner_x == 8'd0 && res.corner_y == 8'd0)
  `GSMC_ASSERT_IMP(a_hit_side, clk, rst, done && res.found, res.side != 9'd0)
  `GSMC_ASSERT_NXT(a_write_rewinds, clk, rst, start && !busy && kind == KIND_WRITE,
                   cur_x == '0 && cur_y == '0)
  `GSMC_ASSERT_IMP(a_no_write_on_read, clk, rst, state == S_SCAN || state == S_GROW, !mem_we)

endmodule

// ===== src/greedy_square_mask_cover.sv =====
`timescale 1ns / 1ps
// Write command: accepted while idle, no result; busy stays low.
// Square request: scans pixel by pixel, column by column, from the cursor; then grows the
// square ring by ring from the first set pixel; then clears the square through the single
// write port; done follows, one cycle wide, cannot be held off.
// Reset: a clearing pass over all MAX_WIDTH*MAX_HEIGHT pixels zeroes the mask with busy high;
// the configuration port works during it. Registers reset to 256 by 256.
module greedy_square_mask_cover import gsmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic        pixel_value,
  // result channel
  output logic        done,
  output logic        square_found,
  output logic [7:0]  corner_x,
  output logic [7:0]  corner_y,
  output logic [8:0]  side,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [8:0]    width_in_use;
  logic [8:0]    height_in_use;
  result_t       res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic          mem_rdata_a;
  logic          mem_rdata_b;

  // Viewport registers; to be written only while the block is idle (the block does not enforce it)
  gsmc_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .width_in_use  (width_in_use),
    .height_in_use (height_in_use)
  );

  // One bit per pixel, addressed x + y*MAX_WIDTH; one write port and two
  // registered read ports so the bottom row and right column of a ring
  // are probed together.
  gsmc_mask_ram #(
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // Sequencer: clear pass, pixel writes, scan, growth and square clear.
  // Scan and growth probes are pipelined one per cycle, pausing at
  // column ends and ring steps; a probe whose answer is decided is dropped.
  gsmc_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_value   (pixel_value),
    .width_in_use  (width_in_use),
    .height_in_use (height_in_use),
    .done          (done),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr_a   (mem_raddr_a),
    .mem_raddr_b   (mem_raddr_b),
    .mem_rdata_a   (mem_rdata_a),
    .mem_rdata_b   (mem_rdata_b)
  );

  // Result transfer fields; valid only in the cycle done is high
  assign square_found = res.found;
  assign corner_x     = res.corner_x;
  assign corner_y     = res.corner_y;
  assign side         = res.side;

endmodule

// ===== tb/sv/square_cover_checker.sv =====
`timescale 1ns / 1ps
module square_cover_checker import gsmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        kind,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic        pixel_value,
  input  logic        done,
  input  logic        square_found,
  input  logic [7:0]  corner_x,
  input  logic [7:0]  corner_y,
  input  logic [8:0]  side,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          waiting,
  output int          carved,
  output int          exhausted
);

  localparam int unsigned MAX_W = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H = DEF_MAX_HEIGHT;

  bit         cover_mask [0:MAX_W*MAX_H-1];
  logic [8:0] scan_col;
  logic [7:0] scan_row;
  logic [8:0] width_setting;
  logic [8:0] height_setting;
  result_t    expected_squares [$];

  function automatic int unsigned pix_index(int unsigned x, int unsigned y);
    return x + y * MAX_W;
  endfunction

  function automatic int unsigned clamp_extent(logic [8:0] setting, int unsigned limit);
    return (setting < limit) ? setting : limit;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Resume the column-major scan, grow a square at the first set pixel, clear it.
  function automatic result_t carve_next_square();
    result_t     r;
    int unsigned w, h, x, y, g, t, bx, by;
    bit          ok;
    w = clamp_extent(width_setting, MAX_W);
    h = clamp_extent(height_setting, MAX_H);
    r = '0;
    for (x = scan_col; x < w; x++) begin
      for (y = (x == scan_col) ? scan_row : 0; y < h; y++) begin
        if (cover_mask[pix_index(x, y)]) begin
          g = 0;
          ok = 1'b1;
          while (ok && y + g + 1 < h && x + g + 1 < w) begin
            for (t = 0; t <= g + 1; t++)
              if (!cover_mask[pix_index(x + t, y + g + 1)] ||
                  !cover_mask[pix_index(x + g + 1, y + t)])
                ok = 1'b0;
            if (ok) g++;
          end
          for (bx = x; bx <= x + g; bx++)
            for (by = y; by <= y + g; by++)
              cover_mask[pix_index(bx, by)] = 1'b0;
          scan_col = 9'(x);
          scan_row = 8'(y);
          r.found = 1'b1;
          r.corner_x = x[7:0];
          r.corner_y = y[7:0];
          r.side = 9'(g + 1);
          return r;
        end
      end
    end
    if (scan_col < w) scan_col = 9'(w);
    scan_row = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (cover_mask[i]) cover_mask[i] = 1'b0;
      scan_col = '0;
      scan_row = '0;
      width_setting = CFG_RESET;
      height_setting = CFG_RESET;
      expected_squares.delete();
      mismatches = 0;
      carved = 0;
      exhausted = 0;
    end else begin
      if (done) begin
        if (expected_squares.size() == 0) begin
          $error("square result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_squares.pop_front();
          check_field("square_found", want.found, square_found);
          check_field("corner_x", want.corner_x, corner_x);
          check_field("corner_y", want.corner_y, corner_y);
          check_field("side", want.side, side);
          if (want.found) carved++;
          else exhausted++;
        end
      end
      if (start && !busy) begin
        if (kind == KIND_WRITE) begin
          if (pixel_x < MAX_W && pixel_y < MAX_H)
            cover_mask[pix_index(pixel_x, pixel_y)] = pixel_value;
          scan_col = '0;
          scan_row = '0;
        end else begin
          expected_squares.push_back(carve_next_square());
        end
      end
      if (psel && penable && pready && paddr[1:0] == 2'b00) begin
        if (pwrite) begin
          if (paddr[2] == REG_WIDTH_IN_USE) width_setting = pwdata[8:0];
          else height_setting = pwdata[8:0];
        end else if (paddr[2] == REG_WIDTH_IN_USE) begin
          check_field("prdata width_in_use", width_setting, prdata[8:0]);
        end else begin
          check_field("prdata height_in_use", height_setting, prdata[8:0]);
        end
      end
    end
    waiting = expected_squares.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import gsmc_pkg::*;

  // Byte addresses of the two viewport registers
  localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH_IN_USE, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT_IN_USE, 2'b00};
  // Reset clears 64K pixels; one request may scan 64K pixels, then grow and clear a
  // large square; allow several times the worst of these
  localparam int STALL_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        kind;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic        pixel_value;
  logic        done;
  logic        square_found;
  logic [7:0]  corner_x;
  logic [7:0]  corner_y;
  logic [8:0]  side;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int waiting;
  int carved;
  int exhausted;

  int          gap_pct;
  int          writes_sent;
  int          requests_sent;
  int          view_changes;
  int          stall_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  greedy_square_mask_cover DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .kind(kind), .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_value(pixel_value),
    .done(done), .square_found(square_found),
    .corner_x(corner_x), .corner_y(corner_y), .side(side),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  square_cover_checker checker_i (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .kind(kind), .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_value(pixel_value),
    .done(done), .square_found(square_found),
    .corner_x(corner_x), .corner_y(corner_y), .side(side),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .waiting(waiting), .carved(carved), .exhausted(exhausted)
  );

  // Watchdog: any command, result or register transfer counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One command transfer. Enter and leave on a falling edge; start is left high at the
  // end and dropped between transfers only for the random gaps set by gap_pct.
  task automatic send(input logic k, input logic [7:0] x, input logic [7:0] y,
                      input logic v);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    kind <= k;
    pixel_x <= x;
    pixel_y <= y;
    pixel_value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (k == KIND_WRITE) writes_sent++;
    else requests_sent++;
  endtask

  task automatic put_pixel(input int unsigned x, input int unsigned y, input bit v);
    send(KIND_WRITE, 8'(x), 8'(y), v);
  endtask

  // Request fields other than kind are don't-care; keep them moving anyway
  task automatic ask_square();
    send(KIND_SQUARE, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Hold off commands until every square answer is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (waiting != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  // Setup phase, access phase held until pready, then an idle phase so the next transfer starts clean
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Change the viewport only while idle, then read both registers back
  task automatic set_view(input int unsigned w, input int unsigned h);
    drain();
    reg_access(1'b1, ADDR_WIDTH, w);
    reg_access(1'b1, ADDR_HEIGHT, h);
    reg_access(1'b0, ADDR_WIDTH, '0);
    reg_access(1'b0, ADDR_HEIGHT, '0);
    view_changes++;
  endtask

  // Mostly small viewports keep scans short; a few single-pixel and wider ones
  function automatic int unsigned pick_extent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 1;
    if (r < 18) return $urandom_range(11, 32);
    return $urandom_range(2, 10);
  endfunction

  // One well-formed episode: new viewport, paint pixels (sometimes a solid block),
  // then carve squares with an occasional write that rewinds the cursor.
  task automatic random_round();
    int unsigned w, h, n, bs, bs_max, ox, oy, i, j, pick;
    w = pick_extent();
    h = pick_extent();
    set_view(w, h);
    n = $urandom_range(2, 12);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)
        send(KIND_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
      else
        put_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1), pick >= 30);
    end
    bs_max = (w < h) ? w : h;
    if (bs_max > 6) bs_max = 6;
    if (bs_max >= 2 && $urandom_range(0, 2) == 0) begin
      bs = $urandom_range(2, bs_max);
      ox = $urandom_range(0, w - bs);
      oy = $urandom_range(0, h - bs);
      for (i = 0; i < bs; i++)
        for (j = 0; j < bs; j++)
          put_pixel(ox + i, oy + j, 1'b1);
    end
    n = $urandom_range(2, 8);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        put_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1), 1'b1);
      else
        ask_square();
    end
  endtask

  initial begin
    int base;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_WRITE;
    pixel_x = '0;
    pixel_y = '0;
    pixel_value = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    writes_sent = 0;
    requests_sent = 0;
    view_changes = 0;
    gap_pct = 31;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers come out of reset at full size; the port works during the clear pass
    reg_access(1'b0, ADDR_WIDTH, '0);
    reg_access(1'b0, ADDR_HEIGHT, '0);

    // Full viewport: a 2x2 at the origin, the far corner, then exhaustion
    set_view(256, 256);
    put_pixel(255, 255, 1'b1);
    put_pixel(0, 0, 1'b1);
    put_pixel(1, 0, 1'b1);
    put_pixel(0, 1, 1'b1);
    put_pixel(1, 1, 1'b1);
    ask_square();
    ask_square();
    ask_square();
    // Rightmost column: a clearing write rewinds the cursor, then a second exhaustion
    put_pixel(255, 0, 1'b1);
    put_pixel(128, 127, 1'b0);
    ask_square();
    ask_square();

    // Empty viewport answers nothing found; then oversized settings clamp to the store
    set_view(0, 5);
    put_pixel(3, 3, 1'b1);
    ask_square();
    set_view(511, 300);
    ask_square();

    // Single-pixel viewport; the pixel below it stays stored for later
    set_view(1, 1);
    put_pixel(0, 0, 1'b1);
    put_pixel(0, 1, 1'b1);
    ask_square();
    ask_square();

    // Grow the view to pick up the hidden pixel, then shrink the height under the
    // cursor row so the scan skips to the next column
    set_view(8, 8);
    put_pixel(2, 5, 1'b1);
    put_pixel(4, 1, 1'b1);
    ask_square();
    ask_square();
    set_view(8, 3);
    ask_square();
    ask_square();

    // Random episodes in three pacing phases
    base = writes_sent + requests_sent;
    while (writes_sent + requests_sent < base + 200) random_round();
    gap_pct = 57;
    while (writes_sent + requests_sent < base + 400) random_round();
    gap_pct = 0;
    while (writes_sent + requests_sent < base + 600) random_round();

    drain();
    repeat (16) @(negedge clk);
    $display("summary: %0d pixel writes, %0d square requests, %0d viewport settings",
             writes_sent, requests_sent, view_changes);
    $display("summary: %0d squares carved, %0d answers of an exhausted mask",
             carved, exhausted);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/gsmc_pkg.sv
src/gsmc_cfg.sv
src/gsmc_mask_ram.sv
src/gsmc_ctrl.sv
src/greedy_square_mask_cover.sv
tb/sv/square_cover_checker.sv
tb/sv/tb_top.sv
